FILE: rtl/nsps_pkg.sv
// Shared types and constants for the nearest seed search block.
// No dependencies; every other file refers to it by scoped names.
package nsps_pkg;

   localparam int COORD_W    = 24;
   localparam int AXES       = 3;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DIST_W     = 50;
   localparam int INDEX_W    = 8;
   localparam int SLOT_W     = 8;
   localparam int GRAIN_W    = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [AXES-1:0] point_type;
   typedef logic [COORD_W-1:0] extent_type;
   typedef extent_type [AXES-1:0] extent_set_type;

   // control that travels alongside each centre through the distance pipe
   typedef struct packed {
      logic               run;
      logic               hit_ok;
      logic               first;
      logic               last;
      logic [INDEX_W-1:0] idx;
   } tag_type;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAIN_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_Z     = 3'd4;

endpackage

FILE: rtl/nsps_req_if.sv
// Request channel: valid/ready handshake carrying a load or query word.
// Depends on nsps_pkg for field widths.
interface nsps_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [nsps_pkg::SLOT_W-1:0]  slot;
   nsps_pkg::coord_type          pos_x;
   nsps_pkg::coord_type          pos_y;
   nsps_pkg::coord_type          pos_z;

   modport source (output valid, mode, slot, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, mode, slot, pos_x, pos_y, pos_z, output ready);
endinterface

FILE: rtl/nsps_rsp_if.sv
// Response channel: valid/ready handshake carrying the nearest centre word.
// Depends on nsps_pkg for field widths.
interface nsps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nsps_pkg::INDEX_W-1:0]  nearest_index;
   logic [nsps_pkg::DIST_W-1:0]   nearest_dist_sq;

   modport source (output valid, nearest_index, nearest_dist_sq, input ready);
   modport sink   (input valid, nearest_index, nearest_dist_sq, output ready);
endinterface

FILE: rtl/nsps_cell.sv
// One storage cell of the centre ring: holds a centre, loads it directly
// or takes its neighbour's centre while the ring rotates. Uses nsps_pkg.
module nsps_cell (
   input  logic                clock,
   input  logic                load_en,
   input  logic                shift_en,
   input  nsps_pkg::point_type load_data,
   input  nsps_pkg::point_type shift_data,
   output nsps_pkg::point_type data
);

   nsps_pkg::point_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_data;
      end else if (shift_en) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: rtl/nsps_dist.sv
// Four-stage squared distance pipe: difference, periodic minimum image,
// square, sum over axes. Depends on nsps_pkg for types and widths.
module nsps_dist (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     periodic,
   input  nsps_pkg::extent_set_type extent,
   input  nsps_pkg::point_type      query,
   input  nsps_pkg::point_type      centre,
   input  nsps_pkg::tag_type        tag_in,
   output logic [nsps_pkg::DIST_W-1:0] dist_sq,
   output nsps_pkg::tag_type        tag_out
);

   localparam int D_W = nsps_pkg::COORD_W + 1;
   localparam int W_W = nsps_pkg::COORD_W + 2;

   function automatic logic [W_W-1:0] mag(input logic signed [W_W-1:0] v);
      mag = v[W_W-1] ? $unsigned(-v) : $unsigned(v);
   endfunction

   // least of |d|, |d-r|, |d+r|; never above |d|, so it fits a coordinate width
   function automatic logic [nsps_pkg::COORD_W-1:0] axis_min(
      input logic signed [D_W-1:0]  d,
      input nsps_pkg::extent_type   r,
      input logic                   per
   );
      logic signed [W_W-1:0] dw;
      logic signed [W_W-1:0] rw;
      logic [W_W-1:0]        m_d;
      logic [W_W-1:0]        m_lo;
      logic [W_W-1:0]        m_hi;
      logic [W_W-1:0]        m;
      dw   = W_W'(d);
      rw   = signed'({2'b00, r});
      m_d  = mag(dw);
      m_lo = mag(dw - rw);
      m_hi = mag(dw + rw);
      m    = m_d;
      if (per) begin
         if (m_lo < m) begin
            m = m_lo;
         end
         if (m_hi < m) begin
            m = m_hi;
         end
      end
      axis_min = m[nsps_pkg::COORD_W-1:0];
   endfunction

   logic signed [D_W-1:0]          diff_ff [nsps_pkg::AXES];
   logic [nsps_pkg::COORD_W-1:0]   min_ff  [nsps_pkg::AXES];
   logic [nsps_pkg::SQ_W-1:0]      sq_ff   [nsps_pkg::AXES];
   logic [nsps_pkg::DIST_W-1:0]    sum_ff;
   nsps_pkg::tag_type              tag_a_ff, tag_b_ff, tag_c_ff, tag_d_ff;

   always_ff @(posedge clock) begin
      for (int a = 0; a < nsps_pkg::AXES; a++) begin
         diff_ff[a] <= D_W'($signed(centre[a])) - D_W'($signed(query[a]));
         min_ff[a]  <= axis_min(diff_ff[a], extent[a], periodic);
         sq_ff[a]   <= nsps_pkg::SQ_W'(min_ff[a]) * nsps_pkg::SQ_W'(min_ff[a]);
      end
      sum_ff <= nsps_pkg::DIST_W'(sq_ff[0]) + nsps_pkg::DIST_W'(sq_ff[1])
              + nsps_pkg::DIST_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
         tag_d_ff <= '0;
      end else begin
         tag_a_ff <= tag_in;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
         tag_d_ff <= tag_c_ff;
      end
   end

   assign dist_sq = sum_ff;
   assign tag_out = tag_d_ff;

endmodule

FILE: rtl/nearest_seed_periodic_search.sv
// Nearest seed search: MAX_SEEDS centres held in a rotating ring of cells,
// one shared squared distance pipe and a running minimum.
// Depends on nsps_pkg, nsps_req_if, nsps_rsp_if, nsps_cell and nsps_dist.
//
// Usage: a req word with mode 0 loads centre (pos_x, pos_y, pos_z) into the
// cell given by slot and gives no response; slots at or above MAX_SEEDS are
// dropped. A req word with mode 1 is a query: the ring rotates once round,
// handing each centre in turn to the distance pipe, so every cell is back in
// place at the end. The first grain_count centres take part. The rsp word
// (nearest_index, nearest_dist_sq) turns valid from the output register once
// the rotation ends, the distance pipe drains and the sequencer emits.
// Registers (csr_we, csr_index, csr_wdata) are to be written only while idle;
// the block itself does not enforce this. Reset sets periodic 0, grain_count 1
// and all ranges 0; centres are not cleared and must be loaded before use. A
// stalled rsp word holds in its output register: loads and one further query
// go on meanwhile, and that query's result waits until the register frees.
module nearest_seed_periodic_search #(
   parameter int MAX_SEEDS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   nsps_req_if.sink                           req,
   nsps_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [nsps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nsps_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CNT_W = (IDX_W > nsps_pkg::GRAIN_W) ? IDX_W : nsps_pkg::GRAIN_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic                            periodic_ff;
   logic [nsps_pkg::GRAIN_W-1:0]    grain_ff;
   nsps_pkg::extent_set_type        extent_ff;
   nsps_pkg::extent_type            lim_ff, lim_in;
   logic [nsps_pkg::SQ_W-1:0]       limsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff <= 1'b0;
         grain_ff    <= nsps_pkg::GRAIN_W'(1);
         extent_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            nsps_pkg::CSR_PERIODIC:    periodic_ff  <= csr_wdata[0];
            nsps_pkg::CSR_GRAIN_COUNT: grain_ff     <= csr_wdata[nsps_pkg::GRAIN_W-1:0];
            nsps_pkg::CSR_RANGE_X:     extent_ff[0] <= csr_wdata;
            nsps_pkg::CSR_RANGE_Y:     extent_ff[1] <= csr_wdata;
            nsps_pkg::CSR_RANGE_Z:     extent_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      lim_in = extent_ff[0];
      if (extent_ff[1] > lim_in) begin
         lim_in = extent_ff[1];
      end
      if (extent_ff[2] > lim_in) begin
         lim_in = extent_ff[2];
      end
   end

   // registered through lim_ff and then limsq_ff, settling well before the first compare
   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      limsq_ff <= nsps_pkg::SQ_W'(lim_ff) * nsps_pkg::SQ_W'(lim_ff);
   end

   // request handling
   logic                req_take;
   logic                load_en;
   logic                query_go;
   nsps_pkg::point_type req_point;
   nsps_pkg::point_type query_ff;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;
   assign load_en   = req_take && (req.mode == nsps_pkg::MODE_LOAD)
                      && (32'(req.slot) < MAX_SEEDS);
   assign query_go  = req_take && (req.mode == nsps_pkg::MODE_QUERY);
   assign req_point = {req.pos_z, req.pos_y, req.pos_x};

   always_ff @(posedge clock) begin
      if (query_go) begin
         query_ff <= req_point;
      end
   end

   // centre ring
   logic                scan_en;
   nsps_pkg::point_type ring [MAX_SEEDS];

   assign scan_en = (state_ff == ST_SCAN);

   for (genvar k = 0; k < MAX_SEEDS; k++) begin : g_cell
      nsps_cell u_cell (
         .clock      (clock),
         .load_en    (load_en && (32'(req.slot) == k)),
         .shift_en   (scan_en),
         .load_data  (req_point),
         .shift_data (ring[(k + 1) % MAX_SEEDS]),
         .data       (ring[k])
      );
   end

   // scan step: the head cell holds centre step_ff
   logic [IDX_W-1:0]    step_ff, step_in;
   logic                step_last;
   nsps_pkg::tag_type   tag_head;

   assign step_last = (step_ff == IDX_W'(MAX_SEEDS - 1));

   always_comb begin
      tag_head.run    = scan_en;
      tag_head.hit_ok = CNT_W'(step_ff) < CNT_W'(grain_ff);
      tag_head.first  = (step_ff == '0);
      tag_head.last   = step_last;
      tag_head.idx    = nsps_pkg::INDEX_W'(step_ff);
   end

   always_comb begin
      step_in = step_ff;
      if (query_go) begin
         step_in = '0;
      end else if (scan_en) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // distance pipe
   logic [nsps_pkg::DIST_W-1:0] pipe_dist;
   nsps_pkg::tag_type           pipe_tag;

   nsps_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .periodic (periodic_ff),
      .extent   (extent_ff),
      .query    (query_ff),
      .centre   (ring[0]),
      .tag_in   (tag_head),
      .dist_sq  (pipe_dist),
      .tag_out  (pipe_tag)
   );

   // running minimum; the first centre compares against the limit squared
   logic [nsps_pkg::DIST_W-1:0]  best_ff, best_in, cmp_dist;
   logic [nsps_pkg::INDEX_W-1:0] best_idx_ff, best_idx_in, cmp_idx;
   logic                         done_ff;

   always_comb begin
      cmp_dist = pipe_tag.first ? nsps_pkg::DIST_W'(limsq_ff) : best_ff;
      cmp_idx  = pipe_tag.first ? '0 : best_idx_ff;
      best_in     = cmp_dist;
      best_idx_in = cmp_idx;
      if (pipe_tag.hit_ok && (pipe_dist < cmp_dist)) begin
         best_in     = pipe_dist;
         best_idx_in = pipe_tag.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_tag.run) begin
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= pipe_tag.run && pipe_tag.last;
      end
   end

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [nsps_pkg::INDEX_W-1:0] rsp_idx_ff;
   logic [nsps_pkg::DIST_W-1:0]  rsp_dist_ff;
   logic                         out_free;
   logic                         emit_go;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit_go  = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_idx_ff  <= best_idx_ff;
         rsp_dist_ff <= best_ff;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.nearest_index   = rsp_idx_ff;
   assign rsp.nearest_dist_sq = rsp_dist_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
